// File: hw/rtl/sha1_hash_engine_defines.svh
// Assertion macros for the SHA-1 hash engine checker.
// No dependencies; included by files that assert.
`ifndef SHA1_HASH_ENGINE_DEFINES_SVH
`define SHA1_HASH_ENGINE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SHA1_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sha1 checker: same-cycle property failed");

// next-cycle implication, disabled in reset
`define SHA1_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sha1 checker: next-cycle property failed");

`endif

// File: hw/rtl/sha1_pkg.sv
// Shared types and constants of the SHA-1 hash engine.
// No dependencies.
package sha1_pkg;

  localparam logic [31:0] Iv0 = 32'h67452301;
  localparam logic [31:0] Iv1 = 32'hEFCDAB89;
  localparam logic [31:0] Iv2 = 32'h98BADCFE;
  localparam logic [31:0] Iv3 = 32'h10325476;
  localparam logic [31:0] Iv4 = 32'hC3D2E1F0;
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [0:0] OpAbsorb = 1'b0;
  localparam logic [0:0] OpFinish = 1'b1;

  typedef enum logic [1:0] {
    SrcData = 2'd0,
    SrcPad  = 2'd1,
    SrcZero = 2'd2,
    SrcLen  = 2'd3
  } byte_src_e;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StRound = 6'b000010,
    StAdd   = 6'b000100,
    StPadZ  = 6'b001000,
    StLen   = 6'b010000,
    StEmit  = 6'b100000
  } state_e;

  typedef struct packed {
    logic      shift_en;
    byte_src_e byte_src;
    logic      count_inc;
    logic      round_init;
    logic      round_en;
    logic      cv_update;
    logic      word_next;
    logic      restart;
  } cmd_t;

  typedef struct packed {
    logic [5:0] pos;
    logic       round_last;
    logic       word_last;
  } status_t;

endpackage

// File: hw/rtl/sha1_dpath.sv
// SHA-1 datapath: block shift register, schedule, round unit, chaining value.
// Depends on sha1_pkg.
module sha1_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sha1_pkg::cmd_t    cmd_i,
  input  logic [7:0]        data_byte_i,
  output sha1_pkg::status_t status_o,
  output logic [31:0]       digest_word_o,
  output logic [2:0]        word_index_o
);

  logic [31:0]  cv_q [5];
  logic [31:0]  cv_d [5];
  logic [31:0]  a_q, b_q, c_q, d_q, e_q;
  logic [31:0]  a_d, b_d, c_d, d_d, e_d;
  logic [511:0] buf_q, buf_d;
  logic [63:0]  cnt_q, cnt_d;
  logic [5:0]   pos_q, pos_d;
  logic [6:0]   rnd_q, rnd_d;
  logic [2:0]   idx_q, idx_d;

  logic [7:0]   in_byte, len_byte;
  logic [5:0]   len_sh;
  logic [31:0]  w0, w2, w8, w13, x, wt, f, k, t;

  assign len_sh   = {3'd7 - pos_q[2:0], 3'b000};
  assign len_byte = 8'(cnt_q >> len_sh);

  always_comb begin
    unique case (cmd_i.byte_src)
      sha1_pkg::SrcData: in_byte = data_byte_i;
      sha1_pkg::SrcPad:  in_byte = sha1_pkg::PadByte;
      sha1_pkg::SrcZero: in_byte = 8'h00;
      sha1_pkg::SrcLen:  in_byte = len_byte;
      default:           in_byte = 8'h00;
    endcase
  end

  assign w0  = buf_q[511:480];
  assign w2  = buf_q[447:416];
  assign w8  = buf_q[255:224];
  assign w13 = buf_q[95:64];
  assign x   = w13 ^ w8 ^ w2 ^ w0;
  assign wt  = (rnd_q < 7'd16) ? w0 : {x[30:0], x[31]};

  always_comb begin
    if (rnd_q < 7'd20) begin
      f = (b_q & c_q) | (~b_q & d_q);
      k = sha1_pkg::K0;
    end else if (rnd_q < 7'd40) begin
      f = b_q ^ c_q ^ d_q;
      k = sha1_pkg::K1;
    end else if (rnd_q < 7'd60) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k = sha1_pkg::K2;
    end else begin
      f = b_q ^ c_q ^ d_q;
      k = sha1_pkg::K3;
    end
  end

  assign t = {a_q[26:0], a_q[31:27]} + f + e_q + k + wt;

  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    pos_d = pos_q;
    rnd_d = rnd_q;
    idx_d = idx_q;
    a_d = a_q; b_d = b_q; c_d = c_q; d_d = d_q; e_d = e_q;
    for (int i = 0; i < 5; i++) cv_d[i] = cv_q[i];
    if (cmd_i.shift_en) begin
      buf_d = {buf_q[503:0], in_byte};
      pos_d = pos_q + 6'd1;
    end
    if (cmd_i.count_inc) cnt_d = cnt_q + 64'd8;
    if (cmd_i.round_init) begin
      a_d = cv_q[0]; b_d = cv_q[1]; c_d = cv_q[2]; d_d = cv_q[3]; e_d = cv_q[4];
      rnd_d = 7'd0;
    end
    if (cmd_i.round_en) begin
      buf_d = {buf_q[479:0], wt};
      a_d = t;
      b_d = a_q;
      c_d = {b_q[1:0], b_q[31:2]};
      d_d = c_q;
      e_d = d_q;
      rnd_d = rnd_q + 7'd1;
    end
    if (cmd_i.cv_update) begin
      cv_d[0] = cv_q[0] + a_q;
      cv_d[1] = cv_q[1] + b_q;
      cv_d[2] = cv_q[2] + c_q;
      cv_d[3] = cv_q[3] + d_q;
      cv_d[4] = cv_q[4] + e_q;
    end
    if (cmd_i.word_next) idx_d = idx_q + 3'd1;
    if (cmd_i.restart) begin
      cv_d[0] = sha1_pkg::Iv0;
      cv_d[1] = sha1_pkg::Iv1;
      cv_d[2] = sha1_pkg::Iv2;
      cv_d[3] = sha1_pkg::Iv3;
      cv_d[4] = sha1_pkg::Iv4;
      cnt_d = 64'd0;
      pos_d = 6'd0;
      idx_d = 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q[0] <= sha1_pkg::Iv0;
      cv_q[1] <= sha1_pkg::Iv1;
      cv_q[2] <= sha1_pkg::Iv2;
      cv_q[3] <= sha1_pkg::Iv3;
      cv_q[4] <= sha1_pkg::Iv4;
      cnt_q   <= 64'd0;
      pos_q   <= 6'd0;
      rnd_q   <= 7'd0;
      idx_q   <= 3'd0;
    end else begin
      for (int i = 0; i < 5; i++) cv_q[i] <= cv_d[i];
      cnt_q <= cnt_d;
      pos_q <= pos_d;
      rnd_q <= rnd_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    a_q <= a_d; b_q <= b_d; c_q <= c_d; d_q <= d_d; e_q <= e_d;
  end

  assign status_o.pos        = pos_q;
  assign status_o.round_last = (rnd_q == 7'd79);
  assign status_o.word_last  = (idx_q == 3'd4);
  assign digest_word_o       = cv_q[idx_q];
  assign word_index_o        = idx_q;

endmodule

// File: hw/rtl/sha1_ctrl.sv
// SHA-1 controller: absorb, padding, compression and digest output sequencing.
// Depends on sha1_pkg.
module sha1_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_op_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  sha1_pkg::status_t status_i,
  output sha1_pkg::cmd_t    cmd_o
);

  sha1_pkg::state_e state_q, state_d;
  logic fin_q, fin_d, done_q, done_d;

  always_comb begin
    state_d = state_q;
    fin_d   = fin_q;
    done_d  = done_q;
    cmd_o   = '0;
    cmd_o.byte_src = sha1_pkg::SrcZero;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      sha1_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.shift_en = 1'b1;
          if (in_op_i == sha1_pkg::OpAbsorb) begin
            cmd_o.byte_src  = sha1_pkg::SrcData;
            cmd_o.count_inc = 1'b1;
            fin_d = 1'b0;
            state_d = sha1_pkg::StIdle;
          end else begin
            cmd_o.byte_src = sha1_pkg::SrcPad;
            fin_d  = 1'b1;
            done_d = 1'b0;
            state_d = sha1_pkg::StPadZ;
          end
          if (status_i.pos == 6'd63) begin
            cmd_o.round_init = 1'b1;
            state_d = sha1_pkg::StRound;
          end
        end
      end
      sha1_pkg::StPadZ: begin
        if (status_i.pos == 6'd56) begin
          state_d = sha1_pkg::StLen;
        end else begin
          cmd_o.shift_en = 1'b1;
          if (status_i.pos == 6'd63) begin
            cmd_o.round_init = 1'b1;
            state_d = sha1_pkg::StRound;
          end
        end
      end
      sha1_pkg::StLen: begin
        cmd_o.shift_en = 1'b1;
        cmd_o.byte_src = sha1_pkg::SrcLen;
        if (status_i.pos == 6'd63) begin
          cmd_o.round_init = 1'b1;
          done_d = 1'b1;
          state_d = sha1_pkg::StRound;
        end
      end
      sha1_pkg::StRound: begin
        cmd_o.round_en = 1'b1;
        if (status_i.round_last) state_d = sha1_pkg::StAdd;
      end
      sha1_pkg::StAdd: begin
        cmd_o.cv_update = 1'b1;
        priority if (fin_q && done_q) state_d = sha1_pkg::StEmit;
        else if (fin_q)               state_d = sha1_pkg::StPadZ;
        else                          state_d = sha1_pkg::StIdle;
      end
      sha1_pkg::StEmit: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (status_i.word_last) begin
            cmd_o.restart = 1'b1;
            fin_d  = 1'b0;
            done_d = 1'b0;
            state_d = sha1_pkg::StIdle;
          end else begin
            cmd_o.word_next = 1'b1;
          end
        end
      end
      default: state_d = sha1_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha1_pkg::StIdle;
      fin_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
      done_q  <= done_d;
    end
  end

endmodule

// File: hw/rtl/sha1_hash_engine.sv
// SHA-1 hash engine top level: byte stream in, five digest words out.
// Absorb: one byte per transfer; the 64th byte of a block starts a compression (80 rounds, then an add).
// Finish: a pad byte, zero fill to byte 56 plus a turn state, 8 length bytes, 1 or 2
// compressions, then 5 output transfers; input is held off until the last one.
// Reset (asynchronous, active low) loads the initial chaining value and clears count and position.
// Depends on sha1_pkg, sha1_ctrl, sha1_dpath.
module sha1_hash_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] operation
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] digest_word, [34:32] word_index, zero above
  output logic        m_axis_tlast_o    // last_word
);

  sha1_pkg::cmd_t    cmd;
  sha1_pkg::status_t status;
  logic [31:0]       digest_word;
  logic [2:0]        word_index;

  sha1_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_op_i     (s_axis_tuser_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sha1_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_byte_i   (s_axis_tdata_i),
    .status_o      (status),
    .digest_word_o (digest_word),
    .word_index_o  (word_index)
  );

  assign m_axis_tdata_o = {5'b00000, word_index, digest_word};
  assign m_axis_tlast_o = status.word_last;

endmodule

// File: hw/rtl/sha1_checker.sv
// Port-level checker for the SHA-1 hash engine, bound to the top level.
// Depends on sha1_hash_engine_defines.svh.
`include "sha1_hash_engine_defines.svh"

module sha1_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  `SHA1_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o))
  `SHA1_ASSERT_NOW(a_no_in_while_out, m_axis_tvalid_o, !s_axis_tready_o)
  `SHA1_ASSERT_NOW(a_last_at_four, m_axis_tvalid_o, m_axis_tlast_o == (m_axis_tdata_o[34:32] == 3'd4))
  `SHA1_ASSERT_NEXT(a_words_follow, m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o, m_axis_tvalid_o)

endmodule

bind sha1_hash_engine sha1_checker u_sha1_checker (.*);
